// ===== rtl/core/bsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types, constants and the binomial table of the Bezier surface
// point evaluator.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // request fields, input side
    typedef struct packed {
        logic               action;
        logic [5:0]         point_index;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
        logic [9:0]         u_step;
        logic [9:0]         v_step;
    } t_in_item;

    // request fields, output side
    typedef struct packed {
        logic signed [23:0] surf_x;
        logic signed [23:0] surf_y;
        logic signed [23:0] surf_z;
    } t_out_item;

    // request kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_U  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_V  = 2'd2;

    localparam logic [3:0] NET_SIDE_RST = 4'd4;
    localparam logic [9:0] STEPS_RST    = 10'd10;

    // binomial table, rows 0..15
    localparam int BIN_W = 13;
    typedef logic [15:0][15:0][BIN_W-1:0] t_binom_tab;

    function automatic t_binom_tab build_binom();
        t_binom_tab tab;
        tab = '0;
        for (int n = 0; n < 16; n++) begin
            tab[n][0] = BIN_W'(1);
            for (int i = 1; i <= n; i++) begin
                tab[n][i] = tab[n-1][i-1] + ((i < n) ? tab[n-1][i] : BIN_W'(0));
            end
        end
        return tab;
    endfunction

    localparam t_binom_tab BINOM_TAB = build_binom();

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_U,
        ST_DIV_U,
        ST_LOAD_V,
        ST_DIV_V,
        ST_BASIS_INIT,
        ST_BASIS_STEP,
        ST_WGT,
        ST_MUL,
        ST_ACC,
        ST_ROUND
    } t_state;

    // datapath commands
    typedef struct packed {
        logic capture;
        logic div_load;
        logic div_axis;
        logic div_step;
        logic div_store;
        logic acc_clr;
        logic basis_init;
        logic basis_step;
        logic use_t;
        logic basis_store;
        logic wgt;
        logic mul;
        logic acc;
        logic out_load;
    } t_dp_cmd;

endpackage

// ===== rtl/core/bsp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bsp_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_ctrl
// Sequencer of the evaluator: handshakes, loop counters and datapath commands.
// ----------------------------------------------------------------------------
module bsp_ctrl
    import bsp_pkg::*;
#(
    parameter int MAX_SIDE  = 8,
    parameter int FRAC_BITS = 16,
    localparam int DEPTH = MAX_SIDE * MAX_SIDE,
    localparam int AW    = $clog2(DEPTH),
    localparam int IW    = $clog2(MAX_SIDE),
    localparam int SW    = $clog2(MAX_SIDE + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    input  logic          i_out_stall,
    input  logic [3:0]    i_net_side,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd,
    output logic [SW-1:0] o_side,
    output logic [IW-1:0] o_bidx,
    output logic [IW-1:0] o_row,
    output logic [IW-1:0] o_col,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr
);

    localparam int CNTW = $clog2(FRAC_BITS + 10);
    localparam logic [CNTW-1:0] DIV_LAST = CNTW'(FRAC_BITS + 9);

    t_state        r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [IW-1:0] r_k, n_k;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_out_valid, n_out_valid;

    logic [4:0]    side_w;
    logic [SW-1:0] side;
    logic [IW-1:0] idx_last;
    logic          accept, div_last, basis_last, i_last, k_last, j_last, out_free;

    // side clamped into 2..MAX_SIDE
    always_comb begin
        side_w = {1'b0, i_net_side};
        if (side_w < 5'd2) begin
            side_w = 5'd2;
        end else if (side_w > 5'(MAX_SIDE)) begin
            side_w = 5'(MAX_SIDE);
        end
    end
    assign side = SW'(side_w);

    // loop end flags
    assign idx_last   = IW'(side_w - 5'd1);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign div_last   = (r_cnt == DIV_LAST);
    assign basis_last = (r_cnt == CNTW'(side_w - 5'd2));
    assign i_last     = (r_i == idx_last);
    assign k_last     = (r_k == idx_last);
    assign j_last     = (r_j == idx_last);
    assign out_free   = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (accept && i_action == ACT_EVAL) n_state = ST_LOAD_U;
            ST_LOAD_U:     n_state = ST_DIV_U;
            ST_DIV_U:      if (div_last) n_state = ST_LOAD_V;
            ST_LOAD_V:     n_state = ST_DIV_V;
            ST_DIV_V:      if (div_last) n_state = ST_BASIS_INIT;
            ST_BASIS_INIT: n_state = ST_BASIS_STEP;
            ST_BASIS_STEP: begin
                if (basis_last) n_state = i_last ? ST_WGT : ST_BASIS_INIT;
            end
            ST_WGT:        n_state = ST_MUL;
            ST_MUL:        n_state = ST_ACC;
            ST_ACC:        n_state = (j_last && k_last) ? ST_ROUND : ST_WGT;
            ST_ROUND:      if (out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd   = '0;
        o_rd_en = 1'b0;
        unique case (r_state)
            ST_IDLE:       o_cmd.capture = accept && (i_action == ACT_EVAL);
            ST_LOAD_U: begin
                o_cmd.div_load = 1'b1;
                o_cmd.acc_clr  = 1'b1;
            end
            ST_DIV_U: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_store = div_last;
            end
            ST_LOAD_V: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_axis = 1'b1;
            end
            ST_DIV_V: begin
                o_cmd.div_axis  = 1'b1;
                o_cmd.div_step  = 1'b1;
                o_cmd.div_store = div_last;
            end
            ST_BASIS_INIT: o_cmd.basis_init = 1'b1;
            ST_BASIS_STEP: begin
                o_cmd.basis_step  = 1'b1;
                o_cmd.use_t       = (r_cnt < CNTW'(r_i));
                o_cmd.basis_store = basis_last;
            end
            ST_WGT: begin
                o_cmd.wgt = 1'b1;
                o_rd_en   = 1'b1;
            end
            ST_MUL:        o_cmd.mul = 1'b1;
            ST_ACC:        o_cmd.acc = 1'b1;
            ST_ROUND:      o_cmd.out_load = out_free;
            default:       o_cmd = '0;
        endcase
    end

    // loop counters and result valid
    always_comb begin
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_addr      = r_addr;
        n_out_valid = o_cmd.out_load || (r_out_valid && i_out_stall);
        case (r_state) inside
            ST_LOAD_U: begin
                n_cnt  = '0;
                n_i    = '0;
                n_j    = '0;
                n_k    = '0;
                n_addr = '0;
            end
            ST_LOAD_V, ST_BASIS_INIT: n_cnt = '0;
            ST_DIV_U, ST_DIV_V:       n_cnt = r_cnt + CNTW'(1);
            ST_BASIS_STEP: begin
                n_cnt = r_cnt + CNTW'(1);
                if (basis_last) n_i = r_i + IW'(1);
            end
            ST_ACC: begin
                n_addr = r_addr + AW'(1);
                if (k_last) begin
                    n_k = '0;
                    n_j = r_j + IW'(1);
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_addr      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_addr      <= n_addr;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_side      = side;
    assign o_bidx      = r_i;
    assign o_row       = r_j;
    assign o_col       = r_k;
    assign o_rd_addr   = r_addr;

endmodule

// ===== rtl/core/bsp_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_dpath
// Arithmetic of the evaluator: shared grid divider, basis multipliers,
// weight multiplier, three coordinate MACs and the rounding stage.
// ----------------------------------------------------------------------------
module bsp_dpath
    import bsp_pkg::*;
#(
    parameter int MAX_SIDE  = 8,
    parameter int FRAC_BITS = 16,
    localparam int IW = $clog2(MAX_SIDE),
    localparam int SW = $clog2(MAX_SIDE + 1)
) (
    input  logic          i_clk,
    input  t_dp_cmd       i_cmd,
    input  logic [SW-1:0] i_side,
    input  logic [IW-1:0] i_bidx,
    input  logic [IW-1:0] i_row,
    input  logic [IW-1:0] i_col,
    input  t_in_item      i_in_item,
    input  logic [9:0]    i_steps_u,
    input  logic [9:0]    i_steps_v,
    input  logic [71:0]   i_rd_data,
    output t_out_item     o_out_item
);

    localparam int NW  = FRAC_BITS + 10;     // divider numerator
    localparam int WB  = FRAC_BITS + BIN_W;  // basis values
    localparam int WW  = FRAC_BITS + 2;      // weights
    localparam int PW  = WW + 25;            // weight times coordinate
    localparam int ACW = PW + 2 * IW;        // accumulator
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [WB+FRAC_BITS:0] HALF_B = (WB+FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
    localparam logic [2*WB-1:0] HALF_W = (2*WB)'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACW-1:0] HALF_A = ACW'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACW-1:0] SAT_HI = ACW'(8388607);
    localparam logic signed [ACW-1:0] SAT_LO = -SAT_HI - ACW'(1);

    logic [9:0]           r_h, r_p;
    logic [NW-1:0]        r_num;
    logic [9:0]           r_rem;
    logic [9:0]           r_div;
    logic [FRAC_BITS-1:0] r_u, r_v;
    logic [WB-1:0]        r_bu_cur, r_bv_cur;
    logic [WB-1:0]        r_bu [MAX_SIDE];
    logic [WB-1:0]        r_bv [MAX_SIDE];
    logic [WW-1:0]        r_wgt;
    logic signed [PW-1:0] r_px, r_py, r_pz;
    logic signed [ACW-1:0] r_ax, r_ay, r_az;
    t_out_item            r_out;

    logic [9:0]           steps, idx, grid;
    logic [NW-1:0]        num;
    logic [10:0]          dtry;
    logic                 dge;
    logic [NW-1:0]        n_num;
    logic [9:0]           n_rem;
    logic [FRAC_BITS:0]   tu, tv;
    logic [WB+FRAC_BITS:0] mu, mv;
    logic [WB-1:0]        n_bu, n_bv;
    logic [2*WB-1:0]      mw;
    logic [3:0]           deg;
    logic signed [23:0]   cx, cy, cz;

    // clamped grid index and rounded numerator of the chosen axis
    always_comb begin
        steps = i_cmd.div_axis ? i_steps_v : i_steps_u;
        grid  = i_cmd.div_axis ? r_p : r_h;
        if (steps == 10'd0) steps = 10'd1;
        idx = (grid >= steps) ? (steps - 10'd1) : grid;
        num = {idx, {FRAC_BITS{1'b0}}} + NW'(steps >> 1);
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        dtry  = {r_rem, r_num[NW-1]};
        dge   = (dtry >= {1'b0, r_div});
        n_rem = dge ? 10'(dtry - {1'b0, r_div}) : dtry[9:0];
        n_num = {r_num[NW-2:0], dge};
    end

    // basis step multipliers
    always_comb begin
        tu   = i_cmd.use_t ? {1'b0, r_u} : (ONE - {1'b0, r_u});
        tv   = i_cmd.use_t ? {1'b0, r_v} : (ONE - {1'b0, r_v});
        mu   = (WB+FRAC_BITS+1)'(r_bu_cur) * (WB+FRAC_BITS+1)'(tu) + HALF_B;
        mv   = (WB+FRAC_BITS+1)'(r_bv_cur) * (WB+FRAC_BITS+1)'(tv) + HALF_B;
        n_bu = mu[FRAC_BITS +: WB];
        n_bv = mv[FRAC_BITS +: WB];
        deg  = 4'(i_side - SW'(1));
    end

    // weight multiplier
    assign mw = (r_bu[i_row] * r_bv[i_col]) + HALF_W;

    assign cx = $signed(i_rd_data[71:48]);
    assign cy = $signed(i_rd_data[47:24]);
    assign cz = $signed(i_rd_data[23:0]);

    // round to nearest and saturate to 24 bits
    function automatic logic signed [23:0] round_sat(input logic signed [ACW-1:0] a);
        logic signed [ACW-1:0] q;
        q = (a + HALF_A) >>> FRAC_BITS;
        if (q > SAT_HI) begin
            return 24'sh7fffff;
        end else if (q < SAT_LO) begin
            return 24'sh800000;
        end
        return q[23:0];
    endfunction

    // grid capture and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_h <= i_in_item.u_step;
            r_p <= i_in_item.v_step;
        end
        if (i_cmd.div_load) begin
            r_num <= num;
            r_rem <= '0;
            r_div <= steps;
        end else if (i_cmd.div_step) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
        if (i_cmd.div_store) begin
            if (i_cmd.div_axis) r_v <= n_num[FRAC_BITS-1:0];
            else                r_u <= n_num[FRAC_BITS-1:0];
        end
    end

    // basis evaluation
    always_ff @(posedge i_clk) begin
        if (i_cmd.basis_init) begin
            r_bu_cur <= {BINOM_TAB[deg][4'(i_bidx)], {FRAC_BITS{1'b0}}};
            r_bv_cur <= {BINOM_TAB[deg][4'(i_bidx)], {FRAC_BITS{1'b0}}};
        end else if (i_cmd.basis_step) begin
            r_bu_cur <= n_bu;
            r_bv_cur <= n_bv;
        end
        if (i_cmd.basis_store) begin
            r_bu[i_bidx] <= n_bu;
            r_bv[i_bidx] <= n_bv;
        end
    end

    // weight, products and accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.wgt) begin
            r_wgt <= mw[FRAC_BITS +: WW];
        end
        if (i_cmd.mul) begin
            r_px <= PW'($signed({1'b0, r_wgt})) * PW'(cx);
            r_py <= PW'($signed({1'b0, r_wgt})) * PW'(cy);
            r_pz <= PW'($signed({1'b0, r_wgt})) * PW'(cz);
        end
        if (i_cmd.acc_clr) begin
            r_ax <= '0;
            r_ay <= '0;
            r_az <= '0;
        end else if (i_cmd.acc) begin
            r_ax <= r_ax + {{(ACW-PW){r_px[PW-1]}}, r_px};
            r_ay <= r_ay + {{(ACW-PW){r_py[PW-1]}}, r_py};
            r_az <= r_az + {{(ACW-PW){r_pz[PW-1]}}, r_pz};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.surf_x <= round_sat(r_ax);
            r_out.surf_y <= round_sat(r_ay);
            r_out.surf_z <= round_sat(r_az);
        end
    end

    assign o_out_item = r_out;

endmodule

// ===== rtl/core/bezier_surface_point_eval_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_surface_point_eval_top
// Tensor-product Bezier surface evaluator over a square control net.
//
// A write request stores one control point. An evaluate request for a net
// of side s runs two grid divisions through one shared bit-serial
// divider, then for each basis index one table load and s - 1 multiply
// steps on a pair of multipliers, then for each control point a weight
// multiply, a coordinate multiply and an accumulate on one weight
// multiplier and the x/y/z multiply-accumulate path that reads the control
// net RAM one point at a time. The result waits in an output register, so
// a new request is taken while the previous result is still stalled.
// Configuration must be written only while the block is idle; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module bezier_surface_point_eval_top
    import bsp_pkg::*;
#(
    parameter int MAX_SIDE  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);

    logic [3:0]    r_net_side;
    logic [9:0]    r_steps_u, r_steps_v;

    t_dp_cmd       cmd;
    logic [SW-1:0] side;
    logic [IW-1:0] bidx, row, col;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [71:0]   rd_data;
    logic [8:0]    wr_idx;
    logic          wr_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_side <= NET_SIDE_RST;
            r_steps_u  <= STEPS_RST;
            r_steps_v  <= STEPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NET_SIDE: r_net_side <= i_cfg_data[3:0];
                CFG_STEPS_U:  r_steps_u  <= i_cfg_data;
                CFG_STEPS_V:  r_steps_v  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control point write, ignored beyond the store
    assign wr_idx = 9'(i_in_item.point_index);
    assign wr_en  = i_in_valid && !o_in_stall && (i_in_item.action == ACT_WRITE)
                    && (wr_idx < 9'(DEPTH));

    bsp_ram #(
        .WIDTH (72),
        .DEPTH (DEPTH)
    ) u_net (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx[AW-1:0]),
        .i_wdata ({i_in_item.coord_x, i_in_item.coord_y, i_in_item.coord_z}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    bsp_ctrl #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_item.action),
        .i_out_stall (i_out_stall),
        .i_net_side  (r_net_side),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .o_side      (side),
        .o_bidx      (bidx),
        .o_row       (row),
        .o_col       (col),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    bsp_dpath #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_side     (side),
        .i_bidx     (bidx),
        .i_row      (row),
        .i_col      (col),
        .i_in_item  (i_in_item),
        .i_steps_u  (r_steps_u),
        .i_steps_v  (r_steps_v),
        .i_rd_data  (rd_data),
        .o_out_item (o_out_item)
    );

endmodule

// ===== rtl/core/bsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bsp_checker
    import bsp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // reset leaves no result and an open input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state not cleared by reset");

    // a pending result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result dropped or changed");

    // an evaluate request blocks further requests
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.action == ACT_EVAL) |=> o_in_stall)
        else $error("evaluate request did not start work");

    // a write request completes at once
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.action == ACT_WRITE) |=> !o_in_stall)
        else $error("write request stalled input");

    // a write request makes no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.action == ACT_WRITE) && !o_out_valid
        |=> !o_out_valid)
        else $error("result from write request");

endmodule

bind bezier_surface_point_eval_top bsp_checker u_bsp_checker (.*);
